// File: src/chc_pkg.sv
// ============================================================================
// Chunk cache package
// Shared types, codes and the controller state type for the chunk cache.
// ============================================================================
`default_nettype none

package chc_pkg;

  localparam int KEY_W    = 56;
  localparam int SIZE_W   = 24;
  localparam int HANDLE_W = 32;
  localparam int STAMP_W  = 64;
  localparam int TOTAL_W  = 36;
  localparam int THR_W    = 40;
  localparam int EVC_W    = 7;

  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [SIZE_W-1:0]   size_t;
  typedef logic [HANDLE_W-1:0] handle_t;
  typedef logic [STAMP_W-1:0]  stamp_t;
  typedef logic [TOTAL_W-1:0]  total_t;
  typedef logic [THR_W-1:0]    thr_t;
  typedef logic [EVC_W-1:0]    evc_t;

  typedef enum logic [1:0] {
    ACT_PROBE = 2'd0,
    ACT_GET   = 2'd1,
    ACT_PUT   = 2'd2
  } action_t;

  localparam evc_t EVC_MAX = 7'd127;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_EVCHK,
    ST_SCAN,
    ST_INSERT
  } state_t;

  // Per-cell strobes from the controller.
  typedef struct packed {
    logic wr;
    logic stamp;
    logic clr;
  } cell_ctl_t;

  // Data broadcast to every cell.
  typedef struct packed {
    key_t    key;
    logic    has_data;
    size_t   size;
    handle_t handle;
    stamp_t  stamp;
  } cell_data_t;

  // Oldest-entry search token passed along the chain.
  typedef struct packed {
    logic   found;
    stamp_t stamp;
  } srch_t;

endpackage

`default_nettype wire

// File: src/chc_in_if.sv
// ============================================================================
// Chunk cache request channel
// Valid/ready channel carrying one cache request per transaction.
// ============================================================================
`default_nettype none

interface chc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  group;
  logic [15:0] chunk_x;
  logic [15:0] chunk_y;
  logic [15:0] chunk_z;
  logic        has_data;
  logic [23:0] chunk_bytes;
  logic [31:0] handle_in;

  modport source (output valid, action, group, chunk_x, chunk_y, chunk_z,
                  has_data, chunk_bytes, handle_in, input ready);
  modport sink (input valid, action, group, chunk_x, chunk_y, chunk_z,
                has_data, chunk_bytes, handle_in, output ready);
endinterface

`default_nettype wire

// File: src/chc_out_if.sv
// ============================================================================
// Chunk cache response channel
// Valid/ready channel carrying one cache response per transaction.
// ============================================================================
`default_nettype none

interface chc_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic        data_present;
  logic [31:0] handle_out;
  logic [6:0]  evicted_count;
  logic        table_full;
  logic [35:0] stored_total;

  modport source (output valid, hit, data_present, handle_out, evicted_count,
                  table_full, stored_total, input ready);
  modport sink (input valid, hit, data_present, handle_out, evicted_count,
                table_full, stored_total, output ready);
endinterface

`default_nettype wire

// File: src/chc_cell.sv
// ============================================================================
// Chunk cache cell
// Holds one table entry, compares its key and forwards the oldest-entry
// search token to the next cell one stage per cycle.
// ============================================================================
`default_nettype none

module chc_cell #(
  parameter int IW  = 6,
  parameter int IDX = 0
) (
  input  wire                  clk,
  input  wire                  rst,
  input  chc_pkg::cell_ctl_t   ctl,
  input  chc_pkg::cell_data_t  wdata,
  input  chc_pkg::key_t        probe_key,
  input  chc_pkg::srch_t       srch_in,
  input  wire [IW-1:0]         idx_in,
  output chc_pkg::srch_t       srch_out,
  output logic [IW-1:0]        idx_out,
  output logic                 match,
  output logic                 valid,
  output logic                 has_data,
  output chc_pkg::size_t       size,
  output chc_pkg::handle_t     handle
);
  import chc_pkg::*;

  key_t   key;
  stamp_t stamp;
  logic   take;

  // Entry valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clr) begin
      valid <= 1'b0;
    end else if (ctl.wr) begin
      valid <= 1'b1;
    end
  end

  // Entry payload and age stamp.
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      key      <= wdata.key;
      has_data <= wdata.has_data;
      size     <= wdata.size;
      handle   <= wdata.handle;
      stamp    <= wdata.stamp;
    end else if (ctl.stamp) begin
      stamp <= wdata.stamp;
    end
  end

  assign match = valid && (key == probe_key);

  // This cell replaces the token when it holds data and either no entry has been found yet or it is strictly older.
  assign take = valid && has_data && (!srch_in.found || (stamp < srch_in.stamp));

  always_ff @(posedge clk) begin
    if (rst) begin
      srch_out.found <= 1'b0;
    end else begin
      srch_out.found <= srch_in.found || take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      srch_out.stamp <= stamp;
      idx_out        <= IW'(IDX);
    end else begin
      srch_out.stamp <= srch_in.stamp;
      idx_out        <= idx_in;
    end
  end

endmodule

`default_nettype wire

// File: src/chunk_cache_lru_byte_budget.sv
// Probe and get: the lookup runs in ST_LOOK, which registers the response.
// Put without eviction: ST_LOOK then ST_INSERT, which registers the response.
// A put at or above the budget adds a threshold check in ST_EVCHK, a chain scan in ST_SCAN
// and a new threshold check per eviction, and a scan when no entry with data is left to evict.
// One request is in flight at a time; the next is taken once the response leaves.
// Synchronous reset empties the table, clears the stored total and the age and scan counters, budget = 2^30.
// ============================================================================
// Chunk cache with LRU eviction under a byte budget
// Controller and chain of entry cells for a chunk cache bookkeeping table.
// ============================================================================
`default_nettype none

module chunk_cache_lru_byte_budget #(
  parameter int TABLE_ENTRIES = 64
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              cfg_we,
  input  wire [35:0]       cfg_wdata,
  chc_in_if.sink           in_ch,
  chc_out_if.source        out_ch
);
  import chc_pkg::*;

  localparam int N  = TABLE_ENTRIES;
  localparam int IW = $clog2(N);
  localparam int CW = $clog2(N + 1);

  // Registers.
  state_t      state, state_next;
  action_t     act;
  key_t        key;
  logic        req_hd;
  size_t       req_bytes;
  handle_t     req_handle;
  logic        hit_r, hit_next;
  logic        present_r, present_next;
  handle_t     hout_r, hout_next;
  evc_t        evc, evc_next;
  logic        full_r, full_next;
  total_t      stored, stored_next;
  stamp_t      age, age_next;
  total_t      budget;
  thr_t        thr9;
  logic [CW-1:0] cnt, cnt_next;
  logic        out_valid, out_valid_next;

  // Cell array signals.
  cell_ctl_t   ctl     [N];
  cell_data_t  wdata;
  srch_t       srch    [N+1];
  logic [IW-1:0] sidx  [N+1];
  logic        c_match [N];
  logic        c_valid [N];
  logic        c_hd    [N];
  size_t       c_size  [N];
  handle_t     c_handle[N];

  // Decoded table views.
  logic          match_any, free_any;
  logic [IW-1:0] match_idx, free_idx, rd_idx, wr_idx;
  logic          rd_hd;
  size_t         rd_size;
  handle_t       rd_handle;
  thr_t          ten_stored;
  logic          do_write, do_stamp, do_clr;
  logic          accept;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state == ST_IDLE) && !out_valid;
  assign srch[0]      = '0;
  assign sidx[0]      = '0;
  assign ten_stored   = {stored, 3'b000} + {2'b00, stored, 1'b0};

  // Chain of entry cells.
  for (genvar i = 0; i < N; i++) begin : g_cell
    chc_cell #(.IW(IW), .IDX(i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl[i]),
      .wdata    (wdata),
      .probe_key(key),
      .srch_in  (srch[i]),
      .idx_in   (sidx[i]),
      .srch_out (srch[i+1]),
      .idx_out  (sidx[i+1]),
      .match    (c_match[i]),
      .valid    (c_valid[i]),
      .has_data (c_hd[i]),
      .size     (c_size[i]),
      .handle   (c_handle[i])
    );
  end

  // Matching slot and lowest free slot.
  always_comb begin
    match_any = 1'b0;
    match_idx = '0;
    free_any  = 1'b0;
    free_idx  = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (c_match[i]) begin
        match_any = 1'b1;
        match_idx = IW'(i);
      end
      if (!c_valid[i]) begin
        free_any = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  // Read mux: eviction victim while scanning, matching slot otherwise.
  assign rd_idx = (state == ST_SCAN) ? sidx[N] : match_idx;

  always_comb begin
    rd_hd     = 1'b0;
    rd_size   = '0;
    rd_handle = '0;
    for (int i = 0; i < N; i++) begin
      if (rd_idx == IW'(i)) begin
        rd_hd     = c_hd[i];
        rd_size   = c_size[i];
        rd_handle = c_handle[i];
      end
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_LOOK;
      end
      ST_LOOK: begin
        if (act == ACT_PUT) begin
          state_next = (stored >= budget) ? ST_EVCHK : ST_INSERT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EVCHK: begin
        state_next = (ten_stored >= thr9) ? ST_SCAN : ST_INSERT;
      end
      ST_SCAN: begin
        if (cnt == '0) state_next = srch[N].found ? ST_EVCHK : ST_INSERT;
      end
      ST_INSERT: begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath and cell control.
  always_comb begin
    hit_next       = hit_r;
    present_next   = present_r;
    hout_next      = hout_r;
    evc_next       = evc;
    full_next      = full_r;
    stored_next    = stored;
    age_next       = age;
    cnt_next       = cnt;
    out_valid_next = out_valid;
    do_write       = 1'b0;
    do_stamp       = 1'b0;
    do_clr         = 1'b0;
    wr_idx         = match_idx;

    if (out_valid && out_ch.ready) out_valid_next = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          present_next = 1'b0;
          hout_next    = '0;
          evc_next     = '0;
          full_next    = 1'b0;
        end
      end
      ST_LOOK: begin
        hit_next = match_any;
        if (act == ACT_GET && match_any) begin
          age_next     = age + 1'b1;
          do_stamp     = 1'b1;
          present_next = rd_hd;
          hout_next    = rd_hd ? rd_handle : '0;
        end
        if (act != ACT_PUT) out_valid_next = 1'b1;
      end
      ST_EVCHK: begin
        cnt_next = CW'(N);
      end
      ST_SCAN: begin
        cnt_next = cnt - 1'b1;
        if (cnt == '0 && srch[N].found) begin
          do_clr      = 1'b1;
          wr_idx      = sidx[N];
          stored_next = stored - TOTAL_W'(rd_size);
          if (evc != EVC_MAX) evc_next = evc + 1'b1;
        end
      end
      ST_INSERT: begin
        out_valid_next = 1'b1;
        if (match_any || free_any) begin
          do_write    = 1'b1;
          wr_idx      = match_any ? match_idx : free_idx;
          age_next    = age + 1'b1;
          stored_next = stored - (match_any ? TOTAL_W'(rd_size) : '0)
                        + (req_hd ? TOTAL_W'(req_bytes) : '0);
        end else begin
          full_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Broadcast data and per-cell strobes.
  assign wdata.key      = key;
  assign wdata.has_data = req_hd;
  assign wdata.size     = req_hd ? req_bytes : '0;
  assign wdata.handle   = req_hd ? req_handle : '0;
  assign wdata.stamp    = age + 1'b1;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      ctl[i].wr    = do_write && (wr_idx == IW'(i));
      ctl[i].stamp = do_stamp && c_match[i];
      ctl[i].clr   = do_clr && (wr_idx == IW'(i));
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      stored    <= '0;
      age       <= '0;
      cnt       <= '0;
      budget    <= 36'd1073741824;
      thr9      <= 40'd9663676416;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      stored    <= stored_next;
      age       <= age_next;
      cnt       <= cnt_next;
      if (cfg_we) begin
        budget <= cfg_wdata;
        thr9   <= {cfg_wdata, 3'b000} + {4'b0000, cfg_wdata};
      end
    end
  end

  // Request and response payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      act        <= action_t'(in_ch.action);
      key        <= {in_ch.group, in_ch.chunk_x, in_ch.chunk_y, in_ch.chunk_z};
      req_hd     <= in_ch.has_data;
      req_bytes  <= in_ch.chunk_bytes;
      req_handle <= in_ch.handle_in;
    end
    hit_r     <= hit_next;
    present_r <= present_next;
    hout_r    <= hout_next;
    evc       <= evc_next;
    full_r    <= full_next;
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.hit           = hit_r;
  assign out_ch.data_present  = present_r;
  assign out_ch.handle_out    = hout_r;
  assign out_ch.evicted_count = evc;
  assign out_ch.table_full    = full_r;
  assign out_ch.stored_total  = stored;

endmodule

`default_nettype wire

// File: tb/sv/tb_chunk_cache_lru_byte_budget.sv
// ============================================================================
// Chunk cache testbench
// Sends probe, get, put and spare-code requests through the request channel.
// A cycle-free model of the LRU table predicts every response, including
// evictions under the byte budget. Each response is then compared field by field.
// ============================================================================
`default_nettype none

module tb_chunk_cache_lru_byte_budget;
  import chc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          SLOTS      = 64;
  localparam logic [1:0]  ACT_SPARE  = 2'd3;
  localparam total_t      BUDGET_MAX = 36'hF_FFFF_FFFF;
  localparam longint      CYCLE_CAP  = 6000000;

  typedef struct {
    logic [1:0]  action;
    logic [7:0]  group;
    logic [15:0] chunk_x;
    logic [15:0] chunk_y;
    logic [15:0] chunk_z;
    logic        has_data;
    size_t       chunk_bytes;
    handle_t     handle_in;
  } request_t;

  typedef struct {
    logic    hit;
    logic    data_present;
    handle_t handle_out;
    evc_t    evicted_count;
    logic    table_full;
    total_t  stored_total;
  } response_t;

  logic   clk;
  logic   rst;
  logic   cfg_we;
  total_t cfg_wdata;

  chc_in_if  in_ch ();
  chc_out_if out_ch ();

  chunk_cache_lru_byte_budget dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Shadow copy of the cache table.
  logic    slot_used   [SLOTS];
  key_t    slot_key    [SLOTS];
  logic    slot_filled [SLOTS];
  size_t   slot_size   [SLOTS];
  handle_t slot_handle [SLOTS];
  stamp_t  slot_age    [SLOTS];
  stamp_t  age_now;
  total_t  bytes_held;
  total_t  budget_now;

  response_t pending_responses[$];
  int        mismatches;
  longint    cycles = 0;
  int        send_idle_pct;
  int        recv_idle_pct;
  key_t      key_pool[$];

  // Clock generation.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Global timeout.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int find_key(key_t k);
    for (int i = 0; i < SLOTS; i++)
      if (slot_used[i] && slot_key[i] == k) return i;
    return -1;
  endfunction

  function automatic int oldest_filled();
    int best;
    best = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (!slot_used[i] || !slot_filled[i]) continue;
      if (best < 0 || slot_age[i] < slot_age[best]) best = i;
    end
    return best;
  endfunction

  // Applies one request to the shadow table and returns the expected response.
  function automatic response_t cache_apply(request_t r);
    response_t   e;
    key_t        k;
    int          slot;
    int          victim;
    logic [63:0] thr;
    k = {r.group, r.chunk_x, r.chunk_y, r.chunk_z};
    slot = find_key(k);
    e = '{hit: slot >= 0, data_present: 1'b0, handle_out: '0, evicted_count: '0,
          table_full: 1'b0, stored_total: '0};
    if (r.action == ACT_GET) begin
      if (slot >= 0) begin
        age_now++;
        slot_age[slot] = age_now;
        if (slot_filled[slot]) begin
          e.data_present = 1'b1;
          e.handle_out = slot_handle[slot];
        end
      end
    end else if (r.action == ACT_PUT) begin
      // Evict oldest data entries until the total drops below nine tenths.
      if (bytes_held >= budget_now) begin
        thr = 64'(budget_now) * 9;
        while (64'(bytes_held) * 10 >= thr) begin
          victim = oldest_filled();
          if (victim < 0) break;
          bytes_held = bytes_held - total_t'(slot_size[victim]);
          slot_used[victim] = 1'b0;
          if (e.evicted_count != EVC_MAX) e.evicted_count++;
        end
        slot = find_key(k);
      end
      if (slot >= 0) begin
        if (slot_filled[slot]) bytes_held = bytes_held - total_t'(slot_size[slot]);
      end else begin
        for (int i = 0; i < SLOTS; i++)
          if (!slot_used[i]) begin
            slot = i;
            break;
          end
      end
      if (slot < 0) begin
        e.table_full = 1'b1;
      end else begin
        slot_used[slot]   = 1'b1;
        slot_key[slot]    = k;
        slot_filled[slot] = r.has_data;
        slot_size[slot]   = r.has_data ? r.chunk_bytes : '0;
        slot_handle[slot] = r.has_data ? r.handle_in : '0;
        if (r.has_data) bytes_held = bytes_held + total_t'(r.chunk_bytes);
        age_now++;
        slot_age[slot] = age_now;
      end
    end
    e.stored_total = bytes_held;
    return e;
  endfunction

  // Response ready with random stalls.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // Compares every response transaction with the oldest prediction.
  always @(posedge clk) begin
    response_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_responses.size() == 0) begin
        $display("%0t: unexpected response, expected none, actual total %0h", $time,
                 out_ch.stored_total);
        mismatches++;
      end else begin
        e = pending_responses.pop_front();
        check_field("hit", e.hit, out_ch.hit);
        check_field("data_present", e.data_present, out_ch.data_present);
        check_field("handle_out", e.handle_out, out_ch.handle_out);
        check_field("evicted_count", e.evicted_count, out_ch.evicted_count);
        check_field("table_full", e.table_full, out_ch.table_full);
        check_field("stored_total", e.stored_total, out_ch.stored_total);
      end
    end
  end

  // Sends one request transaction and records its predicted response.
  task automatic send_request(request_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= r.action;
    in_ch.group       <= r.group;
    in_ch.chunk_x     <= r.chunk_x;
    in_ch.chunk_y     <= r.chunk_y;
    in_ch.chunk_z     <= r.chunk_z;
    in_ch.has_data    <= r.has_data;
    in_ch.chunk_bytes <= r.chunk_bytes;
    in_ch.handle_in   <= r.handle_in;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_responses.push_back(cache_apply(r));
  endtask

  // Drains outstanding responses and leaves the block idle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_budget(total_t value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    budget_now = value;
  endtask

  function automatic request_t make_request(logic [1:0] act, key_t k, logic data,
                                            size_t nbytes, handle_t h);
    request_t r;
    r.action = act;
    {r.group, r.chunk_x, r.chunk_y, r.chunk_z} = k;
    r.has_data = data;
    r.chunk_bytes = nbytes;
    r.handle_in = h;
    return r;
  endfunction

  function automatic key_t random_key();
    return {8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
  endfunction

  // Edge cases at reset budget: misses, hits, empty markers, spare code.
  task automatic test_directed();
    key_t ones;
    key_t zero;
    ones = '1;
    zero = '0;
    send_request(make_request(ACT_PROBE, ones, 1'b0, '0, '0));
    send_request(make_request(ACT_GET, ones, 1'b0, '0, '0));
    send_request(make_request(ACT_PUT, ones, 1'b1, '1, '1));
    send_request(make_request(ACT_GET, ones, 1'b0, '0, '0));
    send_request(make_request(ACT_PROBE, ones, 1'b0, '0, '0));
    send_request(make_request(ACT_PUT, zero, 1'b1, 24'd1, 32'h1));
    send_request(make_request(ACT_PUT, zero, 1'b1, 24'd77, 32'hA5A5_5A5A));
    send_request(make_request(ACT_GET, zero, 1'b0, '0, '0));
    // An empty marker replaces a data entry and drops its bytes.
    send_request(make_request(ACT_PUT, ones, 1'b0, '1, '1));
    send_request(make_request(ACT_GET, ones, 1'b0, '0, '0));
    send_request(make_request(ACT_SPARE, zero, 1'b1, '1, '1));
    send_request(make_request(ACT_SPARE, ones, 1'b0, '0, '0));
    send_request(make_request(ACT_PUT, 56'h12_3456_789A_BCDE, 1'b0, 24'd5, 32'h9));
    send_request(make_request(ACT_GET, 56'h12_3456_789A_BCDE, 1'b0, '0, '0));
    send_request(make_request(ACT_PUT, zero, 1'b1, 24'hFF_FFFF, 32'h0));
    send_request(make_request(ACT_GET, zero, 1'b0, '0, '0));
  endtask

  // With budget of one byte, any stored data is evicted by the next put.
  task automatic test_budget_one();
    write_budget(36'd1);
    for (int i = 0; i < 12; i++)
      send_request(make_request(ACT_PUT, key_t'(i % 4), i % 3 != 0,
                                size_t'($urandom_range(1, 50)), $urandom));
    send_request(make_request(ACT_PUT, key_t'(0), 1'b1, 24'd0, 32'h3));
    send_request(make_request(ACT_GET, key_t'(1), 1'b0, '0, '0));
  endtask

  // With the largest budget nothing is evicted, so the table fills up.
  task automatic test_table_full();
    write_budget(BUDGET_MAX);
    for (int i = 0; i < SLOTS + 6; i++)
      send_request(make_request(ACT_PUT, {8'hC3, 16'(i), 16'hBEEF, 16'(i * 7)},
                                i % 5 != 0, size_t'($urandom), $urandom));
    for (int i = 0; i < 8; i++)
      send_request(make_request(ACT_GET, {8'hC3, 16'(i * 9), 16'hBEEF, 16'(i * 63)},
                                1'b0, '0, '0));
    // Small budget then clears the data entries; the empties stay resident.
    write_budget(36'd100);
    send_request(make_request(ACT_PUT, {8'hC3, 16'd1, 16'hBEEF, 16'd7}, 1'b1,
                              24'd10, 32'h55));
    send_request(make_request(ACT_PUT, random_key(), 1'b1, 24'd10, 32'h66));
  endtask

  // Random traffic over a small pool of keys under a given budget.
  task automatic test_random_traffic(int count, total_t budget, int max_bytes);
    request_t r;
    int       pick;
    write_budget(budget);
    key_pool.delete();
    for (int i = 0; i < 40; i++) key_pool.push_back(random_key());
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      r = make_request(ACT_PROBE, key_pool[$urandom_range(key_pool.size() - 1)],
                       $urandom_range(99) < 85, '0, $urandom);
      if (pick < 45) r.action = ACT_PUT;
      else if (pick < 75) r.action = ACT_GET;
      else if (pick < 96) r.action = ACT_PROBE;
      else r.action = ACT_SPARE;
      if ($urandom_range(99) < 8) r.chunk_bytes = size_t'($urandom);
      else r.chunk_bytes = size_t'($urandom_range(0, max_bytes));
      if ($urandom_range(99) < 5) begin
        {r.group, r.chunk_x, r.chunk_y, r.chunk_z} = random_key();
      end
      send_request(r);
    end
  endtask

  initial begin
    mismatches    = 0;
    cycles        = 0;
    send_idle_pct = 10;
    recv_idle_pct = 54;
    age_now       = '0;
    bytes_held    = '0;
    budget_now    = 36'd1073741824;
    for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.action      <= ACT_PROBE;
    in_ch.group       <= '0;
    in_ch.chunk_x     <= '0;
    in_ch.chunk_y     <= '0;
    in_ch.chunk_z     <= '0;
    in_ch.has_data    <= 1'b0;
    in_ch.chunk_bytes <= '0;
    in_ch.handle_in   <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_budget_one();
    test_table_full();
    test_random_traffic(150, 36'd5000, 1500);
    test_random_traffic(100, 36'd1073741824, 24'hFF_FFFF);

    send_idle_pct = 54;
    recv_idle_pct = 10;
    test_random_traffic(150, 36'd20000, 3000);
    test_random_traffic(80, 36'd1, 100);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(150, 36'd3000, 800);
    test_random_traffic(80, BUDGET_MAX, 24'hFF_FFFF);

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
